// ===== hw/rtl/hhk_pkg.sv =====
// Shared types, codes and reset constants of the handheld hotkey controller.
package hhk_pkg;

  localparam int NUM_BUTTONS_DEF = 7;
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  localparam logic [5:0]  VOLUME_MAX_RST       = 6'd20;
  localparam logic [5:0]  BRIGHTNESS_MAX_RST   = 6'd10;
  localparam logic [11:0] HOLD_FRAMES_RST      = 12'd180;
  localparam logic [5:0]  START_VOLUME_RST     = 6'd10;
  localparam logic [5:0]  START_BRIGHTNESS_RST = 6'd5;
  localparam logic [11:0] HOLD_SAT             = 12'hFFF;

  typedef enum logic [1:0] {
    CMD_BUTTON = 2'd0,
    CMD_JACK   = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    REG_VOLUME_MAX       = 3'd0,
    REG_BRIGHTNESS_MAX   = 3'd1,
    REG_HOLD_FRAMES      = 3'd2,
    REG_START_VOLUME     = 3'd3,
    REG_START_BRIGHTNESS = 3'd4
  } reg_idx_t;

  localparam int BTN_START  = 0;
  localparam int BTN_SELECT = 1;
  localparam int BTN_L      = 2;
  localparam int BTN_R      = 3;
  localparam int BTN_POWER  = 4;
  localparam int BTN_VUP    = 5;
  localparam int BTN_VDOWN  = 6;

  // power-off sequencer, one-hot
  typedef enum logic [2:0] {
    PO_RUN     = 3'b001,
    PO_PENDING = 3'b010,
    PO_HALT    = 3'b100
  } po_t;

  typedef struct packed {
    logic [5:0]  volume_max;
    logic [5:0]  brightness_max;
    logic [11:0] hold_frames;
    logic [5:0]  start_volume;
    logic [5:0]  start_brightness;
    logic        load_volume;
    logic        load_brightness;
  } cfg_t;

  typedef struct packed {
    logic [5:0] volume_level;
    logic [5:0] brightness_level;
    logic       home_pulse;
    logic       jack_report;
    logic       jack_plugged;
    logic       blank_screen;
    logic       shutdown;
  } res_t;

endpackage

// ===== hw/rtl/hhk_regs.sv =====
// APB configuration registers of the hotkey controller.
module hhk_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hhk_pkg::APB_AW-1:0]  paddr,
  input  logic [hhk_pkg::APB_DW-1:0]  pwdata,
  output logic [hhk_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output hhk_pkg::cfg_t               cfg
);
  import hhk_pkg::*;

  logic [5:0]  volume_max;
  logic [5:0]  brightness_max;
  logic [11:0] hold_frames;
  logic [5:0]  start_volume;
  logic [5:0]  start_brightness;
  logic        wr;
  reg_idx_t    idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      volume_max       <= VOLUME_MAX_RST;
      brightness_max   <= BRIGHTNESS_MAX_RST;
      hold_frames      <= HOLD_FRAMES_RST;
      start_volume     <= START_VOLUME_RST;
      start_brightness <= START_BRIGHTNESS_RST;
    end else if (wr) begin
      case (idx)
        REG_VOLUME_MAX:       volume_max       <= pwdata[5:0];
        REG_BRIGHTNESS_MAX:   brightness_max   <= pwdata[5:0];
        REG_HOLD_FRAMES:      hold_frames      <= pwdata[11:0];
        REG_START_VOLUME:     start_volume     <= pwdata[5:0];
        REG_START_BRIGHTNESS: start_brightness <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_VOLUME_MAX:       prdata = {26'd0, volume_max};
      REG_BRIGHTNESS_MAX:   prdata = {26'd0, brightness_max};
      REG_HOLD_FRAMES:      prdata = {20'd0, hold_frames};
      REG_START_VOLUME:     prdata = {26'd0, start_volume};
      REG_START_BRIGHTNESS: prdata = {26'd0, start_brightness};
      default:              prdata = '0;
    endcase
  end

  // start writes also load the live level in the core, same edge
  always_comb begin
    cfg.volume_max       = volume_max;
    cfg.brightness_max   = brightness_max;
    cfg.hold_frames      = hold_frames;
    cfg.start_volume     = pwdata[5:0];
    cfg.start_brightness = pwdata[5:0];
    cfg.load_volume      = wr && (idx == REG_START_VOLUME);
    cfg.load_brightness  = wr && (idx == REG_START_BRIGHTNESS);
  end

endmodule

// ===== hw/rtl/hhk_core.sv =====
// Button, jack and power-hold state with per-tick hotkey evaluation.
module hhk_core #(
  parameter int NUM_BUTTONS = hhk_pkg::NUM_BUTTONS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  hhk_pkg::cfg_t cfg,
  input  logic          item_valid,
  input  logic [1:0]    cmd,
  input  logic [2:0]    button,
  input  logic [1:0]    level,
  output logic          produces,
  output hhk_pkg::res_t res
);
  import hhk_pkg::*;

  logic [NUM_BUTTONS-1:0] held, held_next;
  logic [NUM_BUTTONS-1:0] pressed_edge, pressed_edge_next;
  logic [NUM_BUTTONS-1:0] released_edge, released_edge_next;
  logic [NUM_BUTTONS-1:0] repeat_edge, repeat_edge_next;
  logic [2:0]             jack_state, jack_state_next;
  logic                   chord_seen, chord_seen_next;
  po_t                    po, po_next;
  logic [11:0]            hold_count, hold_count_next;
  logic [5:0]             volume, volume_next;
  logic [5:0]             brightness, brightness_next;

  logic [NUM_BUTTONS-1:0] mask;
  logic                   btn_ok;

  assign btn_ok   = 32'(button) < 32'(NUM_BUTTONS);
  assign mask     = NUM_BUTTONS'(1) << button;
  assign produces = (cmd_t'(cmd) == CMD_TICK) && (po != PO_HALT);

  always_comb begin
    logic pw, sel, st, rl, rr, rvu, rvd, blank;
    held_next          = held;
    pressed_edge_next  = pressed_edge;
    released_edge_next = released_edge;
    repeat_edge_next   = repeat_edge;
    jack_state_next    = jack_state;
    chord_seen_next    = chord_seen;
    po_next            = po;
    hold_count_next    = hold_count;
    volume_next        = volume;
    brightness_next    = brightness;
    pw    = held[BTN_POWER];
    sel   = held[BTN_SELECT];
    st    = held[BTN_START];
    rl    = repeat_edge[BTN_L];
    rr    = repeat_edge[BTN_R];
    rvu   = repeat_edge[BTN_VUP];
    rvd   = repeat_edge[BTN_VDOWN];
    blank = 1'b0;
    res   = '0;

    if (item_valid && po != PO_HALT) begin
      case (cmd_t'(cmd))
        CMD_BUTTON: begin
          if (btn_ok) begin
            if (level != 2'd0) begin
              if ((held & mask) == '0) begin
                held_next         = held | mask;
                pressed_edge_next = pressed_edge | mask;
                repeat_edge_next  = repeat_edge | mask;
              end else begin
                // autorepeat at half rate
                repeat_edge_next = repeat_edge ^ mask;
              end
            end else if ((held & mask) != '0) begin
              released_edge_next = released_edge | mask;
              held_next          = held & ~mask;
              repeat_edge_next   = repeat_edge & ~mask;
            end
          end
        end
        CMD_JACK: begin
          if (level != 2'd0) jack_state_next = jack_state | 3'b011;
          else               jack_state_next = {1'b1, jack_state[1], 1'b0};
        end
        CMD_TICK: begin
          if (pressed_edge[BTN_POWER]) begin
            chord_seen_next = 1'b0;
            hold_count_next = '0;
          end else if (hold_count < HOLD_SAT) begin
            hold_count_next = hold_count + 12'd1;
          end

          if (!chord_seen_next && po == PO_RUN && pw &&
              hold_count_next >= cfg.hold_frames) begin
            po_next = PO_PENDING;
            blank   = 1'b1;
          end

          if (po_next != PO_RUN) begin
            if (released_edge[BTN_POWER]) begin
              res.shutdown = 1'b1;
              po_next      = PO_HALT;
            end
          end else begin
            if ((sel && rl) || (!pw && rvd)) begin
              if (volume != 6'd0) volume_next = volume - 6'd1;
              chord_seen_next = 1'b1;
            end else if ((sel && rr) || (!pw && rvu)) begin
              if (volume < cfg.volume_max) volume_next = volume + 6'd1;
              chord_seen_next = 1'b1;
            end
            if ((st && rl) || (pw && rvd)) begin
              if (brightness != 6'd0) brightness_next = brightness - 6'd1;
              chord_seen_next = 1'b1;
            end else if ((st && rr) || (pw && rvu)) begin
              if (brightness < cfg.brightness_max) brightness_next = brightness + 6'd1;
              chord_seen_next = 1'b1;
            end
            res.home_pulse  = !chord_seen_next && released_edge[BTN_POWER];
            res.jack_report = jack_state[2] || jack_state[1];
          end

          res.blank_screen   = blank;
          res.jack_plugged   = jack_state[0];
          pressed_edge_next  = '0;
          released_edge_next = '0;
          repeat_edge_next   = '0;
          jack_state_next    = {2'b00, jack_state[0]};
        end
        default: ;
      endcase
    end
    res.volume_level     = volume_next;
    res.brightness_level = brightness_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held          <= '0;
      pressed_edge  <= '0;
      released_edge <= '0;
      repeat_edge   <= '0;
      jack_state    <= '0;
      chord_seen    <= 1'b0;
      po            <= PO_RUN;
      hold_count    <= '0;
      volume        <= START_VOLUME_RST;
      brightness    <= START_BRIGHTNESS_RST;
    end else begin
      held          <= held_next;
      pressed_edge  <= pressed_edge_next;
      released_edge <= released_edge_next;
      repeat_edge   <= repeat_edge_next;
      jack_state    <= jack_state_next;
      chord_seen    <= chord_seen_next;
      po            <= po_next;
      hold_count    <= hold_count_next;
      volume        <= cfg.load_volume ? cfg.start_volume : volume_next;
      brightness    <= cfg.load_brightness ? cfg.start_brightness : brightness_next;
    end
  end

  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    po == PO_HALT |=> po == PO_HALT)
    else $error("halted state left without reset");

  a_shutdown_halts: assert property (@(posedge clk) disable iff (rst)
    item_valid && produces && res.shutdown |=> po == PO_HALT)
    else $error("shutdown sent but core not halted");

  a_edges_cleared: assert property (@(posedge clk) disable iff (rst)
    item_valid && produces |=> pressed_edge == '0 && released_edge == '0)
    else $error("edge flags survive a frame tick");

endmodule

// ===== hw/rtl/handheld_hotkey_controller.sv =====
// Top level of the hotkey controller: handshake, item stage, result register.
// A tick beat is registered in the item stage, and its result then in the result register.
// Throughput: one input beat per cycle; the core state updates as a beat moves
//   from the item stage toward the result register; a stalled result only
//   stops the stage when it holds a tick.
// Reset: rst is synchronous, active high; it clears all flags, counters and
//   handshake state, restores register defaults and reloads the start levels.
module handheld_hotkey_controller #(
  parameter int NUM_BUTTONS = hhk_pkg::NUM_BUTTONS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hhk_pkg::APB_AW-1:0]  paddr,
  input  logic [hhk_pkg::APB_DW-1:0]  pwdata,
  output logic [hhk_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  cmd,
  input  logic [2:0]                  button,
  input  logic [1:0]                  level,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [5:0]                  volume_level,
  output logic [5:0]                  brightness_level,
  output logic                        home_pulse,
  output logic                        jack_report,
  output logic                        jack_plugged,
  output logic                        blank_screen,
  output logic                        shutdown
);
  import hhk_pkg::*;

  cfg_t       cfg;
  res_t       res;
  res_t       out_res;
  logic       produces;

  // item stage
  logic       stage_valid;
  logic [1:0] stage_cmd;
  logic [2:0] stage_button;
  logic [1:0] stage_level;
  logic       advance;
  logic       out_free;

  hhk_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hhk_core #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (advance),
    .cmd        (stage_cmd),
    .button     (stage_button),
    .level      (stage_level),
    .produces   (produces),
    .res        (res)
  );

  // A staged beat moves into the core unless it is a tick whose result
  // has nowhere to go yet.
  assign out_free = !out_valid || out_ready;
  assign advance  = stage_valid && (!produces || out_free);
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_cmd    <= cmd;
      stage_button <= button;
      stage_level  <= level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && produces) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produces) begin
      out_res <= res;
    end
  end

  assign volume_level     = out_res.volume_level;
  assign brightness_level = out_res.brightness_level;
  assign home_pulse       = out_res.home_pulse;
  assign jack_report      = out_res.jack_report;
  assign jack_plugged     = out_res.jack_plugged;
  assign blank_screen     = out_res.blank_screen;
  assign shutdown         = out_res.shutdown;

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !advance |=> stage_valid && $stable(stage_cmd)
      && $stable(stage_button) && $stable(stage_level))
    else $error("stalled item stage lost its beat");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> stage_valid)
    else $error("accepted beat not staged");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_res))
    else $error("pending result overwritten");

endmodule
